@@ rtl/dsgc_pkg.sv @@
// Shared constants and types for the DRC static gain curve.
package dsgc_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int LEVEL_W       = 16;
  localparam int GAIN_W        = 14;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int K_MAX         = 64;
  localparam int LUT_N         = K_MAX + 1;

  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 14'sh1fff;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = 14'sh2000;

  localparam logic [2:0] REG_NULL_BAND   = 3'd0;
  localparam logic [2:0] REG_BOOST_MAX   = 3'd1;
  localparam logic [2:0] REG_BOOST_SECT  = 3'd2;
  localparam logic [2:0] REG_CUT_MAX     = 3'd3;
  localparam logic [2:0] REG_CUT_SECT    = 3'd4;

  typedef enum logic [2:0] {
    SEG_BMAX,
    SEG_BO,
    SEG_BI,
    SEG_NULL,
    SEG_CI,
    SEG_CO,
    SEG_CMAX
  } seg_t;

  typedef struct packed {
    logic              vld;
    logic              neg;
    logic signed [6:0] base;
  } tag_t;

endpackage

@@ rtl/dsgc_rdiv.sv @@
// Segment interpolation: product, rounded division by reciprocal, correction, saturation.
module dsgc_rdiv #(
  parameter int FRAC_BITS = dsgc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dsgc_pkg::tag_t                    tag_i,
  input  logic [5:0]                        gmag_i,
  input  logic [FRAC_BITS+6:0]              dist_i,
  input  logic [6:0]                        k_i,
  input  logic [FRAC_BITS+12:0]             recip_i,
  output logic                              valid_o,
  output logic signed [dsgc_pkg::GAIN_W-1:0] gain_o
);

  localparam int NW = FRAC_BITS + 13;
  localparam int QW = FRAC_BITS + 7;
  localparam int VW = (FRAC_BITS + 9 > 15) ? FRAC_BITS + 9 : 15;

  localparam logic signed [VW-1:0] SAT_HI = VW'(dsgc_pkg::GAIN_MAX);
  localparam logic signed [VW-1:0] SAT_LO = VW'(dsgc_pkg::GAIN_MIN);

  dsgc_pkg::tag_t  tag_c_r, tag_d_r, tag_e_r;
  logic [NW-1:0]   p_c_r, p_nxt;
  logic [6:0]      k_c_r;
  logic [NW-1:0]   r_c_r;

  logic [NW-1:0]   n_nxt, n_d_r, n_e_r;
  logic [2*NW-1:0] nr;
  logic [QW-1:0]   q_nxt, q_d_r, q_e_r;
  logic [7:0]      d_nxt, d_d_r, d_e_r;

  logic [NW-1:0]   prod_nxt, prod_e_r;

  logic [NW-1:0]        rem;
  logic                 bump;
  logic [QW-1:0]        q_fin;
  logic signed [VW-1:0] base_q, val;
  logic signed [dsgc_pkg::GAIN_W-1:0] gain_nxt;
  logic                 valid_r;
  logic signed [dsgc_pkg::GAIN_W-1:0] gain_r;

  // product of gain step and distance into the segment
  assign p_nxt = NW'(gmag_i) * NW'(dist_i);

  // numerator 2P + k over divisor 2k; reciprocal estimate is exact or one low
  assign n_nxt = {p_c_r[NW-2:0], 1'b0} + NW'(k_c_r);
  assign nr    = (2*NW)'(n_nxt) * (2*NW)'(r_c_r);
  assign q_nxt = nr[NW+QW-1:NW];
  assign d_nxt = {k_c_r, 1'b0};

  assign prod_nxt = NW'(q_d_r) * NW'(d_d_r);

  always_comb begin
    rem    = n_e_r - prod_e_r;
    bump   = (d_e_r != 8'd0) && (rem >= NW'(d_e_r));
    q_fin  = q_e_r + QW'(bump);
    base_q = VW'(tag_e_r.base) <<< FRAC_BITS;
    if (tag_e_r.neg) begin
      val = base_q - $signed(VW'(q_fin));
    end else begin
      val = base_q + $signed(VW'(q_fin));
    end
    if (val > SAT_HI) begin
      gain_nxt = dsgc_pkg::GAIN_MAX;
    end else if (val < SAT_LO) begin
      gain_nxt = dsgc_pkg::GAIN_MIN;
    end else begin
      gain_nxt = val[dsgc_pkg::GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c_r <= '0;
      tag_d_r <= '0;
      tag_e_r <= '0;
      valid_r <= 1'b0;
    end else begin
      tag_c_r <= tag_i;
      tag_d_r <= tag_c_r;
      tag_e_r <= tag_d_r;
      valid_r <= tag_e_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    p_c_r    <= p_nxt;
    k_c_r    <= k_i;
    r_c_r    <= recip_i;
    n_d_r    <= n_nxt;
    q_d_r    <= q_nxt;
    d_d_r    <= d_nxt;
    n_e_r    <= n_d_r;
    q_e_r    <= q_d_r;
    d_e_r    <= d_d_r;
    prod_e_r <= prod_nxt;
    gain_r   <= gain_nxt;
  end

  assign valid_o = valid_r;
  assign gain_o  = gain_r;

endmodule

@@ rtl/drc_static_gain_curve.sv @@
// Top level of the DRC static gain curve: register file, curve points, segment select.
//
// Usage: one signed level (dB, FRAC_BITS fraction bits) enters on in_level_db
// with start; busy stays low, so a level can be taken in every cycle.
// Each level gives exactly one gain on out_gain_db, marked by out_valid for a
// single cycle, in the order in which the levels were taken.
// Throughput is one level per clock; the pipeline is input register, compare,
// segment select, multiply, reciprocal multiply, check multiply, round and
// saturate. The receiver cannot hold results off, so nothing ever stalls.
// The curve is set through the APB port (psel/penable/pwrite/paddr/pwdata,
// prdata, pready always high); registers sit at byte addresses 0, 4, 8, 12
// and 16; the user must write them only while no level is in flight, which the
// block itself does not enforce. The curve points are re-derived from the
// registers in the cycle after a write. Synchronous reset (rst_n low) clears
// the register file to zero, giving 0 dB everywhere, and empties the pipeline.
module drc_static_gain_curve #(
  parameter int FRAC_BITS = dsgc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dsgc_pkg::LEVEL_W-1:0] in_level_db,
  output logic                                out_valid,
  output logic signed [dsgc_pkg::GAIN_W-1:0]  out_gain_db,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dsgc_pkg::ADDR_W-1:0]         paddr,
  input  logic [dsgc_pkg::DATA_W-1:0]         pwdata,
  output logic [dsgc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int CW = (FRAC_BITS + 9 > 17) ? FRAC_BITS + 9 : 17;
  localparam int DW = FRAC_BITS + 7;
  localparam int NW = FRAC_BITS + 13;

  logic [7:0]  null_band_r;
  logic [8:0]  boost_max_r;
  logic [9:0]  boost_sect_r;
  logic [10:0] cut_max_r;
  logic [10:0] cut_sect_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  logic signed [7:0] nl_nxt, nh_nxt, sbl_nxt, mbl_nxt, scl_nxt, mcl_nxt;
  logic signed [6:0] mbg_nxt, sbg_nxt, scg_nxt, mcg_nxt, gbo_nxt, gco_nxt;
  logic [6:0]        kbo_nxt, kbi_nxt, kci_nxt, kco_nxt;

  logic signed [7:0] nl_r, nh_r, sbl_r, mbl_r, scl_r, mcl_r;
  logic signed [6:0] mbg_r, sbg_r, scg_r, mcg_r, gbo_r, gco_r;
  logic [6:0]        kbo_r, kbi_r, kci_r, kco_r;
  logic [NW-1:0]     rbo_r, rbi_r, rci_r, rco_r;

  logic [NW-1:0] recip_lut [dsgc_pkg::LUT_N];

  logic                                v0_r;
  logic signed [dsgc_pkg::LEVEL_W-1:0] lv0_r;
  logic signed [CW-1:0]                lv0x;

  dsgc_pkg::seg_t                      seg_nxt, seg_a_r;
  logic                                va_r;
  logic signed [dsgc_pkg::LEVEL_W-1:0] lva_r;
  logic signed [CW-1:0]                lvax;

  logic signed [6:0]    g_sel, base_nxt;
  logic signed [CW-1:0] diff;
  logic [6:0]           k_nxt;
  logic [NW-1:0]        r_nxt;
  logic [5:0]           gmag_nxt;
  dsgc_pkg::tag_t       tag_nxt, tag_b_r;
  logic [5:0]           gmag_b_r;
  logic [DW-1:0]        dist_b_r;
  logic [6:0]           k_b_r;
  logic [NW-1:0]        r_b_r;

  function automatic logic signed [CW-1:0] bp_q(input logic signed [7:0] b);
    logic signed [CW-1:0] bx;
    bx   = CW'(b);
    bp_q = bx <<< FRAC_BITS;
  endfunction

  // register file
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_band_r  <= '0;
      boost_max_r  <= '0;
      boost_sect_r <= '0;
      cut_max_r    <= '0;
      cut_sect_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        dsgc_pkg::REG_NULL_BAND:  null_band_r  <= pwdata[7:0];
        dsgc_pkg::REG_BOOST_MAX:  boost_max_r  <= pwdata[8:0];
        dsgc_pkg::REG_BOOST_SECT: boost_sect_r <= pwdata[9:0];
        dsgc_pkg::REG_CUT_MAX:    cut_max_r    <= pwdata[10:0];
        dsgc_pkg::REG_CUT_SECT:   cut_sect_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsgc_pkg::REG_NULL_BAND:  prdata = dsgc_pkg::DATA_W'(null_band_r);
      dsgc_pkg::REG_BOOST_MAX:  prdata = dsgc_pkg::DATA_W'(boost_max_r);
      dsgc_pkg::REG_BOOST_SECT: prdata = dsgc_pkg::DATA_W'(boost_sect_r);
      dsgc_pkg::REG_CUT_MAX:    prdata = dsgc_pkg::DATA_W'(cut_max_r);
      dsgc_pkg::REG_CUT_SECT:   prdata = dsgc_pkg::DATA_W'(cut_sect_r);
      default:                  prdata = '0;
    endcase
  end

  // curve points in whole dB; spans in dB (zero where a segment cannot be reached)
  always_comb begin
    nl_nxt  = -$signed({4'd0, null_band_r[3:0]});
    nh_nxt  = $signed({4'd0, null_band_r[7:4]});
    mbg_nxt = $signed({3'd0, boost_max_r[3:0]});
    kbi_nxt = boost_sect_r[0] ? 7'd1 + {2'd0, boost_sect_r[9:5]} : 7'd0;
    sbg_nxt = boost_sect_r[0] ? $signed(7'd1 + {3'd0, boost_sect_r[4:1]}) : 7'sd0;
    sbl_nxt = nl_nxt - $signed({1'b0, kbi_nxt});
    kbo_nxt = (boost_max_r[3:0] != 4'd0) ? 7'd1 + {2'd0, boost_max_r[8:4]} : 7'd0;
    mbl_nxt = (boost_max_r[3:0] != 4'd0) ? sbl_nxt - $signed({1'b0, kbo_nxt}) : nl_nxt;
    mcg_nxt = -$signed({2'd0, cut_max_r[4:0]});
    kci_nxt = cut_sect_r[0] ? 7'd1 + {2'd0, cut_sect_r[10:6]} : 7'd0;
    scg_nxt = cut_sect_r[0] ? -$signed(7'd1 + {2'd0, cut_sect_r[5:1]}) : 7'sd0;
    scl_nxt = nh_nxt + $signed({1'b0, kci_nxt});
    kco_nxt = (cut_max_r[4:0] != 5'd0) ? 7'd1 + {1'b0, cut_max_r[10:5]} : 7'd0;
    mcl_nxt = (cut_max_r[4:0] != 5'd0) ? scl_nxt + $signed({1'b0, kco_nxt}) : nh_nxt;
    gbo_nxt = mbg_nxt - sbg_nxt;
    gco_nxt = mcg_nxt - scg_nxt;
  end

  // floor(2^NW / 2k), zero for an empty span
  for (genvar gi = 0; gi < dsgc_pkg::LUT_N; gi++) begin : g_recip
    localparam logic [63:0] RV = (gi == 0) ? 64'd0 : (64'd1 << NW) / 64'(2 * gi);
    assign recip_lut[gi] = RV[NW-1:0];
  end

  always_ff @(posedge clk) begin
    nl_r  <= nl_nxt;
    nh_r  <= nh_nxt;
    sbl_r <= sbl_nxt;
    mbl_r <= mbl_nxt;
    scl_r <= scl_nxt;
    mcl_r <= mcl_nxt;
    mbg_r <= mbg_nxt;
    sbg_r <= sbg_nxt;
    scg_r <= scg_nxt;
    mcg_r <= mcg_nxt;
    gbo_r <= gbo_nxt;
    gco_r <= gco_nxt;
    kbo_r <= kbo_nxt;
    kbi_r <= kbi_nxt;
    kci_r <= kci_nxt;
    kco_r <= kco_nxt;
    rbo_r <= recip_lut[kbo_nxt];
    rbi_r <= recip_lut[kbi_nxt];
    rci_r <= recip_lut[kci_nxt];
    rco_r <= recip_lut[kco_nxt];
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    lv0_r <= in_level_db;
  end

  // stage A: locate the segment
  assign lv0x = CW'(lv0_r);

  always_comb begin
    if (lv0x < bp_q(mbl_r)) begin
      seg_nxt = dsgc_pkg::SEG_BMAX;
    end else if (lv0x <= bp_q(sbl_r)) begin
      seg_nxt = dsgc_pkg::SEG_BO;
    end else if (lv0x <= bp_q(nl_r)) begin
      seg_nxt = dsgc_pkg::SEG_BI;
    end else if (lv0x <= bp_q(nh_r)) begin
      seg_nxt = dsgc_pkg::SEG_NULL;
    end else if (lv0x <= bp_q(scl_r)) begin
      seg_nxt = dsgc_pkg::SEG_CI;
    end else if (lv0x <= bp_q(mcl_r)) begin
      seg_nxt = dsgc_pkg::SEG_CO;
    end else begin
      seg_nxt = dsgc_pkg::SEG_CMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    seg_a_r <= seg_nxt;
    lva_r   <= lv0_r;
  end

  // stage B: segment operands
  assign lvax = CW'(lva_r);

  always_comb begin
    base_nxt = 7'sd0;
    g_sel    = 7'sd0;
    diff     = '0;
    k_nxt    = 7'd0;
    r_nxt    = '0;
    case (seg_a_r)
      dsgc_pkg::SEG_BMAX: begin
        base_nxt = mbg_r;
      end
      dsgc_pkg::SEG_BO: begin
        base_nxt = sbg_r;
        g_sel    = gbo_r;
        diff     = bp_q(sbl_r) - lvax;
        k_nxt    = kbo_r;
        r_nxt    = rbo_r;
      end
      dsgc_pkg::SEG_BI: begin
        g_sel = sbg_r;
        diff  = bp_q(nl_r) - lvax;
        k_nxt = kbi_r;
        r_nxt = rbi_r;
      end
      dsgc_pkg::SEG_NULL: ;
      dsgc_pkg::SEG_CI: begin
        g_sel = scg_r;
        diff  = lvax - bp_q(nh_r);
        k_nxt = kci_r;
        r_nxt = rci_r;
      end
      dsgc_pkg::SEG_CO: begin
        base_nxt = scg_r;
        g_sel    = gco_r;
        diff     = lvax - bp_q(scl_r);
        k_nxt    = kco_r;
        r_nxt    = rco_r;
      end
      dsgc_pkg::SEG_CMAX: begin
        base_nxt = mcg_r;
      end
      default: ;
    endcase
    gmag_nxt     = g_sel[6] ? 6'(-g_sel) : g_sel[5:0];
    tag_nxt.vld  = va_r;
    tag_nxt.neg  = g_sel[6];
    tag_nxt.base = base_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
    end else begin
      tag_b_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gmag_b_r <= gmag_nxt;
    dist_b_r <= diff[DW-1:0];
    k_b_r    <= k_nxt;
    r_b_r    <= r_nxt;
  end

  dsgc_rdiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_i   (tag_b_r),
    .gmag_i  (gmag_b_r),
    .dist_i  (dist_b_r),
    .k_i     (k_b_r),
    .recip_i (r_b_r),
    .valid_o (out_valid),
    .gain_o  (out_gain_db)
  );

endmodule
